// ----- hw/rtl/sorted_list_engine_unit_assert.svh -----
// Assertion macros for the sorted list engine.
// Included by the top level; no other dependencies.
`ifndef SORTED_LIST_ENGINE_UNIT_ASSERT_SVH
`define SORTED_LIST_ENGINE_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Property checked on every rising clock edge outside reset.
`define SLE_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("sorted list engine: assertion failed");
// Implication checked on every rising clock edge outside reset.
`define SLE_ASSERT_IMPL(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
    else $error("sorted list engine: assertion failed");
`else
`define SLE_ASSERT(label, clk, rst_n, prop)
`define SLE_ASSERT_IMPL(label, clk, rst_n, pre, post)
`endif

`endif

// ----- hw/rtl/sle_pkg.sv -----
// Shared types and constants of the sorted list engine.
// No dependencies.
package sle_pkg;

  localparam int unsigned KindWidth   = 2;
  localparam int unsigned StatusWidth = 2;
  localparam int unsigned ValueWidth  = 32;
  localparam int unsigned CountWidth  = 5;

  typedef enum logic [KindWidth-1:0] {
    OP_INSERT = 2'd0,
    OP_APPEND = 2'd1,
    OP_DELETE = 2'd2,
    OP_POP    = 2'd3
  } sle_op_e;

  typedef enum logic [StatusWidth-1:0] {
    ST_DONE      = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_EMPTY     = 2'd3
  } sle_status_e;

  // Command broadcast to every cell.
  typedef struct packed {
    sle_op_e op;
    logic    en;   // accepted beat that changes the list
  } sle_cmd_t;

endpackage

// ----- hw/rtl/sle_cell.sv -----
// One slot of the sorted list: holds an entry and shifts with its neighbors.
// Depends on sle_pkg.
module sle_cell #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                  clk_i,
  input  sle_pkg::sle_cmd_t     cmd_i,
  input  logic [DATA_WIDTH-1:0] value_i,
  input  logic                  occupied_i,  // slot index below fill
  input  logic                  at_fill_i,   // slot index equals fill
  input  logic [DATA_WIDTH-1:0] left_data_i,
  input  logic [DATA_WIDTH-1:0] right_data_i,
  input  logic                  chain_i,     // a slot to the left already hit
  output logic                  chain_o,
  output logic [DATA_WIDTH-1:0] data_o
);

  logic [DATA_WIDTH-1:0] data_q, data_d;
  logic                  hit;

  always_comb begin
    case (cmd_i.op)
      sle_pkg::OP_INSERT: hit = !occupied_i || ($signed(data_q) >= $signed(value_i));
      sle_pkg::OP_DELETE: hit = occupied_i && (data_q == value_i);
      default:            hit = 1'b0;
    endcase
  end

  assign chain_o = chain_i | hit;

  always_comb begin
    data_d = data_q;
    case (cmd_i.op)
      sle_pkg::OP_INSERT: begin
        if (chain_o) data_d = chain_i ? left_data_i : value_i;
      end
      sle_pkg::OP_APPEND: begin
        if (at_fill_i) data_d = value_i;
      end
      sle_pkg::OP_DELETE: begin
        if (chain_o) data_d = right_data_i;
      end
      default: data_d = right_data_i;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.en) data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

// ----- hw/rtl/sorted_list_engine_unit.sv -----
// Top level of the sorted list engine: cell chain, fill count, result register.
// Depends on sle_pkg, sle_cell and sorted_list_engine_unit_assert.svh.

// Sorted list engine. Keeps an ordered list of up to DEPTH signed values in a
// row of cells, entry 0 being the head. Each input beat carries a command in
// tuser (insert in order, append at tail, delete first match, pop head) and a
// value in tdata; each command yields exactly one result beat with a status,
// the popped value and the count held afterwards. A command completes in the
// cycle it is accepted: every cell compares its entry with the broadcast
// value, a hit flag ripples cell to cell to find the first position, and all
// cells shift in that same edge. One beat is taken per cycle while the result
// register is empty or being drained, so throughput is one command per clock;
// the clock period is set by the compare plus the hit ripple through DEPTH
// cells. The result beat is registered and offered the cycle after its input.
// Reset needs no clearing pass: only slots below the fill count are ever read.
module sorted_list_engine_unit #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [31:0] value
  input  logic [1:0]  s_axis_tuser_i,   // [1:0] kind
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // [31:0] popped, [36:32] count_after, rest zero
  output logic [1:0]  m_axis_tuser_o    // [1:0] status
);

  `include "sorted_list_engine_unit_assert.svh"

  localparam int unsigned FillWidth = $clog2(DEPTH + 1);
  localparam int unsigned PadWidth  = 40 - sle_pkg::ValueWidth - sle_pkg::CountWidth;

  // List state
  logic [FillWidth-1:0]  fill_q, fill_d;
  logic [DATA_WIDTH-1:0] cell_data [DEPTH];
  logic [DEPTH:0]        chain;

  // Result register
  logic                           out_valid_q;
  sle_pkg::sle_status_e           status_q, status_d;
  logic [sle_pkg::ValueWidth-1:0] popped_q, popped_d;
  logic [sle_pkg::CountWidth-1:0] count_q;

  logic                  in_beat;
  logic                  is_full, is_empty;
  sle_pkg::sle_op_e      op;
  sle_pkg::sle_cmd_t     cmd;
  logic [DATA_WIDTH-1:0] value_ext;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_beat         = s_axis_tvalid_i && s_axis_tready_o;

  assign op        = sle_pkg::sle_op_e'(s_axis_tuser_i);
  assign value_ext = DATA_WIDTH'($signed(s_axis_tdata_i));
  assign is_full   = (fill_q == FillWidth'(DEPTH));
  assign is_empty  = (fill_q == '0);

  // Decide whether the beat changes the list, the new count and the status.
  always_comb begin
    cmd.op   = op;
    cmd.en   = 1'b0;
    fill_d   = fill_q;
    status_d = sle_pkg::ST_DONE;
    popped_d = '0;
    case (op)
      sle_pkg::OP_INSERT, sle_pkg::OP_APPEND: begin
        if (is_full) begin
          status_d = sle_pkg::ST_FULL;
        end else begin
          cmd.en = in_beat;
          fill_d = fill_q + 1'b1;
        end
      end
      sle_pkg::OP_DELETE: begin
        cmd.en = in_beat;
        if (chain[DEPTH]) fill_d = fill_q - 1'b1;
        else status_d = sle_pkg::ST_NOT_FOUND;
      end
      default: begin
        if (is_empty) begin
          status_d = sle_pkg::ST_EMPTY;
        end else begin
          cmd.en   = in_beat;
          fill_d   = fill_q - 1'b1;
          popped_d = sle_pkg::ValueWidth'(cell_data[0]);
        end
      end
    endcase
  end

  // Cell chain: hit flag ripples from head to tail.
  assign chain[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_data, right_data;

    if (i == 0) begin : g_head
      assign left_data = value_ext;
    end else begin : g_body
      assign left_data = cell_data[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_data = cell_data[i];
    end else begin : g_inner
      assign right_data = cell_data[i+1];
    end

    sle_cell #(
      .DATA_WIDTH(DATA_WIDTH)
    ) u_cell (
      .clk_i       (clk_i),
      .cmd_i       (cmd),
      .value_i     (value_ext),
      .occupied_i  (FillWidth'(i) < fill_q),
      .at_fill_i   (FillWidth'(i) == fill_q),
      .left_data_i (left_data),
      .right_data_i(right_data),
      .chain_i     (chain[i]),
      .chain_o     (chain[i+1]),
      .data_o      (cell_data[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_beat) begin
        fill_q      <= fill_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      status_q <= status_d;
      popped_q <= popped_d;
      count_q  <= sle_pkg::CountWidth'(fill_d);
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = status_q;
  assign m_axis_tdata_o  = {{PadWidth{1'b0}}, count_q, popped_q};

  // Checks
  `SLE_ASSERT(a_fill_bound, clk_i, rst_ni, fill_q <= FillWidth'(DEPTH))
  `SLE_ASSERT(a_count_tracks_fill, clk_i, rst_ni,
              !out_valid_q || (count_q == sle_pkg::CountWidth'(fill_q)))
  `SLE_ASSERT_IMPL(a_pop_shrinks, clk_i, rst_ni,
                   in_beat && (op == sle_pkg::OP_POP) && !is_empty,
                   fill_q == $past(fill_q) - 1'b1)

endmodule
